>>> src/lob_pkg.sv
// shared types and codes for the limit order book matcher
// request/response payloads, sweep token, sweep setup and slot commands
// no dependencies
package lob_pkg;

    localparam int IDX_BITS = 16;

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_MODIFY = 2'd1,
        OP_VOLUME = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        order_side;
        logic [15:0] order_price;
        logic [31:0] order_quantity;
        logic [31:0] order_ident;
    } req_t;

    typedef struct packed {
        logic [8:0]  match_count;
        logic        found;
        logic [31:0] volume;
        logic        found_side;
        logic [15:0] found_price;
        logic [31:0] found_quantity;
        logic        book_full;
    } rsp_t;

    typedef enum logic [1:0] {
        SW_MATCH  = 2'd0,
        SW_FIND   = 2'd1,
        SW_VOLUME = 2'd2,
        SW_CANCEL = 2'd3
    } sweep_kind_t;

    typedef struct packed {
        sweep_kind_t kind;
        logic        side;
        logic [31:0] limit;
        logic [31:0] ident;
        logic [31:0] now;
    } sweep_t;

    typedef struct packed {
        logic                active;
        logic                best_found;
        logic [IDX_BITS-1:0] best_idx;
        logic [31:0]         best_price;
        logic [31:0]         best_age;
        logic [31:0]         best_qty;
        logic                free_found;
        logic [IDX_BITS-1:0] free_idx;
        logic [31:0]         vol;
        logic                any_hit;
    } tok_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_SETQTY = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [IDX_BITS-1:0] idx;
        logic [31:0]         qty;
        logic                side;
        logic [31:0]         price;
        logic [31:0]         ident;
        logic [31:0]         arrival;
    } cmd_t;

endpackage

>>> src/limit_order_book_matcher.sv
// two-sided limit order book with price-time priority matching
// top level: controller plus a row of BOOK_SLOTS cells; depends on lob_pkg,
// lob_cell and lob_ctrl
//
// usage
//   request channel req_valid/req_ready/req, response channel
//   rsp_valid/rsp_ready/rsp; one response per request, in order
//   every search is a token that walks the cell row one slot per cycle;
//   one sweep is a launch state, then the walk down the row to the tail
//   volume and cancel: one sweep; lookup: one or two sweeps; modify by id:
//   one or two sweeps plus an apply step when the id is found
//   submit with f fills: f sweeps when filled in full, else f + 1 sweeps,
//   plus an apply step per fill and for a resting remainder; zero quantity
//   takes no sweep; a finish state then loads the output register, which
//   holds the response until it is taken
//   the next request can be taken once the finish state has gone back to
//   idle, while the held response waits; if the receiver stalls, that request
//   completes its sweeps and then waits until the held response is taken
//   reset empties the book and zeroes the arrival stamp counter at once
module limit_order_book_matcher import lob_pkg::*;
#(
    parameter int BOOK_SLOTS = 256,
    parameter int PRICE_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    sweep_t sw;
    cmd_t   cmd;
    tok_t   chain [BOOK_SLOTS+1];

    lob_ctrl #(
        .PRICE_BITS (PRICE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .sw        (sw),
        .cmd       (cmd),
        .tok_head  (chain[0]),
        .tok_tail  (chain[BOOK_SLOTS])
    );

    for (genvar g = 0; g < BOOK_SLOTS; g++)
    begin : g_cell
        lob_cell #(
            .PRICE_BITS (PRICE_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .sw      (sw),
            .cmd     (cmd),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

endmodule

>>> src/lob_cell.sv
// one book slot: holds a resting order and passes the sweep token on
// depends on lob_pkg
module lob_cell import lob_pkg::*;
#(
    parameter int PRICE_BITS = 16,
    parameter int CELL_IDX   = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  sweep_t sw,
    input  cmd_t   cmd,
    input  tok_t   tok_in,
    output tok_t   tok_out
);

    logic                  valid_reg;
    logic                  side_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [31:0]           qty_reg;
    logic [31:0]           ident_reg;
    logic [31:0]           arrival_reg;
    tok_t                  tok_reg;
    tok_t                  tok_next;

    logic [31:0] price_ext;
    logic [31:0] age;
    logic [31:0] fill_left;
    logic [32:0] vol_sum;
    logic        same_side;
    logic        crosses;
    logic        cand;
    logic        better;
    logic        id_hit;
    logic        cmd_hit;
    logic        cancel_hit;

    always_comb
    begin
        price_ext  = 32'(price_reg);
        age        = sw.now - arrival_reg;
        fill_left  = qty_reg - cmd.qty;
        vol_sum    = {1'b0, tok_in.vol} + {1'b0, qty_reg};
        same_side  = valid_reg && (side_reg == sw.side);
        crosses    = sw.side ? (price_ext <= sw.limit) : (price_ext >= sw.limit);
        id_hit     = valid_reg && (ident_reg == sw.ident);
        cmd_hit    = (cmd.idx == IDX_BITS'(CELL_IDX));
        cancel_hit = tok_in.active && (sw.kind == SW_CANCEL) && id_hit;
        case (sw.kind)
            SW_MATCH: cand = same_side && crosses;
            SW_FIND:  cand = same_side && id_hit;
            default:  cand = 1'b0;
        endcase
        if (!tok_in.best_found)
        begin
            better = 1'b1;
        end
        else if (price_ext != tok_in.best_price)
        begin
            better = sw.side ? (price_ext < tok_in.best_price)
                             : (price_ext > tok_in.best_price);
        end
        else
        begin
            better = age > tok_in.best_age;
        end

        tok_next = tok_in;
        if (cand && better)
        begin
            tok_next.best_found = 1'b1;
            tok_next.best_idx   = IDX_BITS'(CELL_IDX);
            tok_next.best_price = price_ext;
            tok_next.best_age   = age;
            tok_next.best_qty   = qty_reg;
        end
        if (!valid_reg && !tok_in.free_found)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = IDX_BITS'(CELL_IDX);
        end
        if (sw.kind == SW_VOLUME && same_side && price_ext == sw.limit)
        begin
            tok_next.vol = vol_sum[32] ? 32'hFFFF_FFFF : vol_sum[31:0];
        end
        if (cancel_hit)
        begin
            tok_next.any_hit = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (cancel_hit)
            begin
                valid_reg <= 1'b0;
            end
            else if (cmd_hit && cmd.kind == CMD_WRITE)
            begin
                valid_reg <= 1'b1;
            end
            else if (cmd_hit && cmd.kind == CMD_FILL && fill_left == 32'd0)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_hit)
        begin
            case (cmd.kind)
                CMD_WRITE:
                begin
                    side_reg    <= cmd.side;
                    price_reg   <= cmd.price[PRICE_BITS-1:0];
                    qty_reg     <= cmd.qty;
                    ident_reg   <= cmd.ident;
                    arrival_reg <= cmd.arrival;
                end
                CMD_FILL:   qty_reg <= fill_left;
                CMD_SETQTY: qty_reg <= cmd.qty;
                default:    ;
            endcase
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> src/lob_ctrl.sv
// request sequencer: launches sweeps down the cell row, applies fills, writes and
// quantity updates, holds the response register; depends on lob_pkg
module lob_ctrl import lob_pkg::*;
#(
    parameter int PRICE_BITS = 16
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  req_t   req,
    output logic   rsp_valid,
    input  logic   rsp_ready,
    output rsp_t   rsp,
    output sweep_t sw,
    output cmd_t   cmd,
    output tok_t   tok_head,
    input  tok_t   tok_tail
);

    localparam logic [31:0] PRICE_MASK = 32'((64'd1 << PRICE_BITS) - 64'd1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LAUNCH = 5'b00010,
        ST_WAIT   = 5'b00100,
        ST_APPLY  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    op_t         op_reg, op_next;
    logic        side_reg, side_next;
    logic [31:0] price_reg, price_next;
    logic [31:0] qty_reg, qty_next;
    logic [31:0] id_reg, id_next;
    logic [8:0]  fills_reg, fills_next;
    logic        found_reg, found_next;
    logic [31:0] vol_reg, vol_next;
    logic        fside_reg, fside_next;
    logic [15:0] fprice_reg, fprice_next;
    logic [31:0] fqty_reg, fqty_next;
    logic        full_reg, full_next;
    logic        again_reg, again_next;
    logic [31:0] arrival_reg, arrival_next;
    sweep_t      sw_reg, sw_next;
    cmd_t        cmd_reg, cmd_next;
    rsp_t        rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;

    logic [31:0] req_price;
    logic [31:0] take;

    always_comb
    begin
        req_price = 32'(req.order_price) & PRICE_MASK;
        take      = (qty_reg < tok_tail.best_qty) ? qty_reg : tok_tail.best_qty;

        state_next     = state_reg;
        op_next        = op_reg;
        side_next      = side_reg;
        price_next     = price_reg;
        qty_next       = qty_reg;
        id_next        = id_reg;
        fills_next     = fills_reg;
        found_next     = found_reg;
        vol_next       = vol_reg;
        fside_next     = fside_reg;
        fprice_next    = fprice_reg;
        fqty_next      = fqty_reg;
        full_next      = full_reg;
        again_next     = again_reg;
        arrival_next   = arrival_reg;
        sw_next        = sw_reg;
        cmd_next       = cmd_reg;
        cmd_next.kind  = CMD_NONE;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        tok_head        = '0;
        tok_head.active = (state_reg == ST_LAUNCH);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = req.op;
                    side_next    = req.order_side;
                    price_next   = req_price;
                    qty_next     = req.order_quantity;
                    id_next      = req.order_ident;
                    fills_next   = '0;
                    found_next   = 1'b0;
                    vol_next     = '0;
                    fside_next   = 1'b0;
                    fprice_next  = '0;
                    fqty_next    = '0;
                    full_next    = 1'b0;
                    sw_next.now   = arrival_reg;
                    sw_next.limit = req_price;
                    sw_next.ident = req.order_ident;
                    sw_next.side  = 1'b0;
                    state_next    = ST_LAUNCH;
                    case (req.op)
                        OP_SUBMIT:
                        begin
                            sw_next.kind = SW_MATCH;
                            sw_next.side = !req.order_side;
                            if (req.order_quantity == 32'd0)
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        OP_MODIFY:
                        begin
                            sw_next.kind = (req.order_quantity == 32'd0) ? SW_CANCEL
                                                                         : SW_FIND;
                        end
                        OP_VOLUME:
                        begin
                            sw_next.kind = SW_VOLUME;
                            sw_next.side = req.order_side;
                        end
                        default:
                        begin
                            sw_next.kind = SW_FIND;
                        end
                    endcase
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (tok_tail.active)
                begin
                    state_next = ST_FINISH;
                    case (op_reg)
                        OP_SUBMIT:
                        begin
                            if (tok_tail.best_found)
                            begin
                                cmd_next.kind = CMD_FILL;
                                cmd_next.idx  = tok_tail.best_idx;
                                cmd_next.qty  = take;
                                qty_next      = qty_reg - take;
                                if (fills_reg != 9'h1FF)
                                begin
                                    fills_next = fills_reg + 9'd1;
                                end
                                again_next = (qty_reg != take);
                                state_next = ST_APPLY;
                            end
                            else if (tok_tail.free_found)
                            begin
                                cmd_next.kind    = CMD_WRITE;
                                cmd_next.idx     = tok_tail.free_idx;
                                cmd_next.qty     = qty_reg;
                                cmd_next.side    = side_reg;
                                cmd_next.price   = price_reg;
                                cmd_next.ident   = id_reg;
                                cmd_next.arrival = arrival_reg;
                                arrival_next     = arrival_reg + 32'd1;
                                again_next       = 1'b0;
                                state_next       = ST_APPLY;
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        OP_MODIFY:
                        begin
                            if (sw_reg.kind == SW_CANCEL)
                            begin
                                found_next = tok_tail.any_hit;
                            end
                            else if (tok_tail.best_found)
                            begin
                                found_next    = 1'b1;
                                cmd_next.kind = CMD_SETQTY;
                                cmd_next.idx  = tok_tail.best_idx;
                                cmd_next.qty  = qty_reg;
                                again_next    = 1'b0;
                                state_next    = ST_APPLY;
                            end
                            else if (!sw_reg.side)
                            begin
                                sw_next.side = 1'b1;
                                state_next   = ST_LAUNCH;
                            end
                        end
                        OP_VOLUME:
                        begin
                            vol_next = tok_tail.vol;
                        end
                        default:
                        begin
                            if (tok_tail.best_found)
                            begin
                                found_next  = 1'b1;
                                fside_next  = sw_reg.side;
                                fprice_next = tok_tail.best_price[15:0];
                                fqty_next   = tok_tail.best_qty;
                            end
                            else if (!sw_reg.side)
                            begin
                                sw_next.side = 1'b1;
                                state_next   = ST_LAUNCH;
                            end
                        end
                    endcase
                end
            end
            ST_APPLY:
            begin
                state_next = again_reg ? ST_LAUNCH : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.match_count    = fills_reg;
                    rsp_next.found          = found_reg;
                    rsp_next.volume         = vol_reg;
                    rsp_next.found_side     = fside_reg;
                    rsp_next.found_price    = fprice_reg;
                    rsp_next.found_quantity = fqty_reg;
                    rsp_next.book_full      = full_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            arrival_reg   <= '0;
            cmd_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            arrival_reg   <= arrival_next;
            cmd_reg       <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        side_reg   <= side_next;
        price_reg  <= price_next;
        qty_reg    <= qty_next;
        id_reg     <= id_next;
        fills_reg  <= fills_next;
        found_reg  <= found_next;
        vol_reg    <= vol_next;
        fside_reg  <= fside_next;
        fprice_reg <= fprice_next;
        fqty_reg   <= fqty_next;
        full_reg   <= full_next;
        again_reg  <= again_next;
        sw_reg     <= sw_next;
        rsp_reg    <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign sw        = sw_reg;
    assign cmd       = cmd_reg;

endmodule
